/* hw/rtl/motor_speed_estimator_bemf_ripple_top_macros.svh */
// assertion macros for the motor speed estimator
// no dependencies; included by files that carry concurrent assertions
`ifndef MOTOR_SPEED_ESTIMATOR_BEMF_RIPPLE_TOP_MACROS_SVH
`define MOTOR_SPEED_ESTIMATOR_BEMF_RIPPLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MSEBR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define MSEBR_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define MSEBR_ASSERT(lbl, prop, msg)
`define MSEBR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* hw/rtl/msebr_pkg.sv */
// shared constants and codes for the motor speed estimator
// no dependencies
package msebr_pkg;

   localparam int FILTER_FRAC_BITS_DEF = 24;

   // field widths
   localparam int MV_W    = 15;
   localparam int MA_W    = 14;
   localparam int FQ_W    = 18;
   localparam int POLE_W  = 8;
   localparam int SEED_W  = 20;
   localparam int SPEED_W = 16;
   localparam int BEMF_W  = 15;

   // internal widths
   localparam int NUM_W  = 22;  // ripple freq times 15
   localparam int DEN_W  = 11;  // eight times pole count
   localparam int UV_W   = 25;  // millivolts times 1000
   localparam int DROP_W = 35;  // current times resistance in microvolts
   localparam int EB_W   = 36;  // signed back-emf
   localparam int KN_W   = 36;  // back-emf times den

   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLE_COUNT = 2'd0,
      CSR_RES_SEED   = 2'd1,
      CSR_KE_SEED    = 2'd2
   } csr_index_type;

   localparam logic [POLE_W-1:0] POLE_RESET = 8'd5;
   localparam logic [SEED_W-1:0] RES_RESET  = 20'd20000;
   localparam logic [SEED_W-1:0] KE_RESET   = 20'd15000;

endpackage

/* hw/rtl/motor_speed_estimator_bemf_ripple_top.sv */
// motor speed estimator fusing commutator ripple and back-emf
// depends on msebr_pkg and motor_speed_estimator_bemf_ripple_top_macros.svh
//
// usage
//   request channel req_*: applied voltage, average current and ripple
//   frequency; a request is taken when req_valid is high and req_stall low
//   result channel rsp_*: speed, back-emf, learned resistance and ke, source
//   flag and stall flag; one result per request, held while rsp_stall is high
//   csr channel: index 0 pole count, 1 resistance seed, 2 ke seed; a zero
//   write is ignored, seed writes reload the learned filter
// sequencing
//   one request at a time; req_stall is high while the sequencer works
//   every division, filter step and the back-emf scaling to millivolts
//   goes through one restoring divider, one quotient bit per cycle; a
//   request that learns resistance or ke makes extra divider passes
// reset
//   synchronous, active high; restores pole count 5, resistance 20000 mohm,
//   ke 15000 uv/rpm, speed zero and the source flag to back-emf
// stall
//   a finished result waits in the output register; a new request may be
//   taken meanwhile, its result waits in the sequencer until the old one leaves
`include "motor_speed_estimator_bemf_ripple_top_macros.svh"

module motor_speed_estimator_bemf_ripple_top
   import msebr_pkg::*;
#(
   parameter int FILTER_FRAC_BITS = FILTER_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [MV_W-1:0]      req_applied_mv,
   input  logic [MA_W-1:0]      req_current_ma,
   input  logic [FQ_W-1:0]      req_ripple_freq_q4,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [SPEED_W-1:0]   rsp_speed_rpm,
   output logic [BEMF_W-1:0]    rsp_bemf_mv,
   output logic [SEED_W-1:0]    rsp_resistance_mohm,
   output logic [SEED_W-1:0]    rsp_ke_out_uv_per_rpm,
   output logic                 rsp_used_ripple,
   output logic                 rsp_stalled,
   // csr write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SEED_W-1:0]    csr_wdata
);

   localparam int F  = FILTER_FRAC_BITS;
   localparam int YW = SEED_W + F;          // filter state width
   localparam int AW = UV_W + 2 * F;        // dividend and quotient width
   localparam int DW = YW;                  // divisor width
   localparam int CW = $clog2(AW + 1);      // divider step counter width
   localparam int MW = (F > SEED_W) ? F : SEED_W;
   localparam int PW = UV_W + MW;           // multiplier product
   localparam int RW = UV_W + F;            // back-emf rpm quotient

   localparam logic [RW-1:0] CAP_Q   = RW'(65535) << F;
   localparam logic [RW-1:0] FLOOR_Q = RW'(200) << F;
   localparam logic [YW-1:0] STALL_Q = YW'(20) << F;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIV,
      ST_RIP_DONE,
      ST_RES_DONE,
      ST_DROP_A,
      ST_DROP_B,
      ST_DROP_C,
      ST_KE_EB,
      ST_KE_RANGE,
      ST_KE_DONE,
      ST_BEMF_CALC,
      ST_BEMF_Q,
      ST_SEL,
      ST_SM_START,
      ST_SM_APPLY,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      TGT_RES,
      TGT_KE,
      TGT_SPEED
   } tgt_type;

   // control state
   state_type state_ff, state_in, ret_ff, ret_in;
   tgt_type sm_tgt_ff, sm_tgt_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [POLE_W-1:0] pole_ff, pole_in;
   logic [YW-1:0] res_ff, res_in, ke_ff, ke_in, speed_ff, speed_in;
   logic rip_sel_ff, rip_sel_in;
   logic drop_ke_ff, drop_ke_in;
   logic rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [AW-1:0] dq_ff, dq_in;
   logic [DW-1:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [MV_W-1:0] mv_ff, mv_in;
   logic [MA_W-1:0] ma_ff, ma_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [YW-1:0] rip_q_ff, rip_q_in, sm_x_ff, sm_x_in;
   logic sm_neg_ff, sm_neg_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [DROP_W-1:0] p1_ff, p1_in, drop_ff, drop_in;
   logic [UV_W-1:0] bemf_ff, bemf_in;
   logic [BEMF_W-1:0] bemf_mv_ff, bemf_mv_in;
   logic [SPEED_W-1:0] o_speed_ff, o_speed_in;
   logic [BEMF_W-1:0] o_bemf_ff, o_bemf_in;
   logic [SEED_W-1:0] o_res_ff, o_res_in, o_ke_ff, o_ke_in;
   logic o_used_ff, o_used_in, o_stall_ff, o_stall_in;

   // combinational helpers
   logic [DEN_W-1:0] den;
   logic [NUM_W-1:0] req_num;
   logic [UV_W-1:0] mv_k;
   logic [DW:0] rem_sh, rem_sub;
   logic rem_ge;
   logic [UV_W-1:0] mul_a;
   logic [MW-1:0] mul_b;
   logic [PW-1:0] mul_p;
   logic signed [EB_W-1:0] eb;
   logic [UV_W-1:0] bemf_cur;
   logic [YW-1:0] sm_y, sm_q, sm_new;
   logic [YW:0] sm_diff;
   logic [YW-1:0] sm_mag;
   logic [DW-1:0] sm_div;
   logic [KN_W-1:0] kn;
   logic [RW-1:0] brpm, raw;
   logic win, r_learn, k_go, valid_rip, rip_hi, rip_lo;

   assign den     = {pole_ff, 3'b000};
   assign req_num = NUM_W'(req_ripple_freq_q4) * NUM_W'(15);
   assign mv_k    = UV_W'(mv_ff) * UV_W'(1000);

   // shared restoring divider step
   assign rem_sh  = {rem_ff, dq_ff[AW-1]};
   assign rem_ge  = rem_sh >= {1'b0, dsr_ff};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};

   // shared multiplier
   assign mul_p = mul_a * mul_b;

   assign eb = $signed(EB_W'(mv_k)) - $signed(EB_W'(drop_ff));
   assign bemf_cur = ((mv_ff < MV_W'(100)) || ((ma_ff < MA_W'(150)) && (mv_ff < MV_W'(3000)))
                      || eb[EB_W-1]) ? '0 : eb[UV_W-1:0];

   assign win     = (mv_ff > MV_W'(280)) && (mv_ff < MV_W'(1400));
   assign r_learn = (ma_ff > MA_W'(100)) && win
                    && (20'(mv_ff) > (20'(ma_ff) << 3))
                    && (20'(mv_ff) < 20'(ma_ff) * 20'd60);
   assign k_go    = (ma_ff > MA_W'(100)) && !win
                    && (32'(num_ff) > 32'(den) * 32'd1000)
                    && (mv_ff > MV_W'(5000));

   assign valid_rip = (num_ff != '0) && (ma_ff > MA_W'(350)) && (mv_ff > MV_W'(3000));
   assign rip_hi    = 32'(num_ff) > 32'(den) * 32'd1200;
   assign rip_lo    = 32'(num_ff) < 32'(den) * 32'd1000;

   assign kn   = prod_ff[KN_W-1:0];
   assign brpm = dq_ff[RW-1:0];

   // filter smoothing operands
   always_comb begin
      case (sm_tgt_ff)
         TGT_RES: begin
            sm_y   = res_ff;
            sm_div = DW'(500);
         end
         TGT_KE: begin
            sm_y   = ke_ff;
            sm_div = DW'(1000);
         end
         default: begin
            sm_y   = speed_ff;
            sm_div = DW'(10);
         end
      endcase
   end

   assign sm_diff = {1'b0, sm_x_ff} - {1'b0, sm_y};
   assign sm_mag  = sm_diff[YW] ? YW'(~sm_diff + 1'b1) : sm_diff[YW-1:0];
   assign sm_q    = dq_ff[YW-1:0];
   assign sm_new  = sm_neg_ff ? (sm_y - sm_q) : (sm_y + sm_q);

   // source selection with hysteresis, cap and low-speed floor
   always_comb begin
      rip_sel_in = rip_sel_ff;
      if (valid_rip && rip_hi) begin
         raw        = RW'(rip_q_ff);
         rip_sel_in = 1'b1;
      end else if (!valid_rip || rip_lo) begin
         raw        = brpm;
         rip_sel_in = 1'b0;
      end else begin
         raw = rip_sel_ff ? RW'(rip_q_ff) : brpm;
      end
      if (raw > CAP_Q) begin
         raw = CAP_Q;
      end
      if (!valid_rip && (mv_ff < MV_W'(3000)) && (raw < FLOOR_Q)) begin
         raw = '0;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      cnt_in       = cnt_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      pole_in      = pole_ff;
      res_in       = res_ff;
      ke_in        = ke_ff;
      speed_in     = speed_ff;
      drop_ke_in   = drop_ke_ff;
      sm_tgt_in    = sm_tgt_ff;
      sm_x_in      = sm_x_ff;
      sm_neg_in    = sm_neg_ff;
      mv_in        = mv_ff;
      ma_in        = ma_ff;
      num_in       = num_ff;
      rip_q_in     = rip_q_ff;
      prod_in      = prod_ff;
      p1_in        = p1_ff;
      drop_in      = drop_ff;
      bemf_in      = bemf_ff;
      bemf_mv_in   = bemf_mv_ff;
      o_speed_in   = o_speed_ff;
      o_bemf_in    = o_bemf_ff;
      o_res_in     = o_res_ff;
      o_ke_in      = o_ke_ff;
      o_used_in    = o_used_ff;
      o_stall_in   = o_stall_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_a        = '0;
      mul_b        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               case (csr_index)
                  CSR_POLE_COUNT: begin
                     if (csr_wdata[POLE_W-1:0] != '0) begin
                        pole_in = csr_wdata[POLE_W-1:0];
                     end
                  end
                  CSR_RES_SEED: begin
                     if (csr_wdata != '0) begin
                        res_in = {csr_wdata, F'(0)};
                     end
                  end
                  CSR_KE_SEED: begin
                     if (csr_wdata != '0) begin
                        ke_in = {csr_wdata, F'(0)};
                     end
                  end
                  default: ;
               endcase
            end
            if (req_valid) begin
               mv_in    = req_applied_mv;
               ma_in    = req_current_ma;
               num_in   = req_num;
               dq_in    = AW'(req_num) << (AW - NUM_W);
               rem_in   = '0;
               dsr_in   = DW'(den);
               cnt_in   = CW'(NUM_W + F);
               ret_in   = ST_RIP_DONE;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            dq_in  = {dq_ff[AW-2:0], rem_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               state_in = ret_ff;
            end
         end
         ST_RIP_DONE: begin
            rip_q_in = dq_ff[YW-1:0];
            if (r_learn) begin
               // instant resistance: mv * 1000 / ma
               dq_in    = AW'(mv_k) << (AW - UV_W);
               rem_in   = '0;
               dsr_in   = DW'(ma_ff);
               cnt_in   = CW'(UV_W + F);
               ret_in   = ST_RES_DONE;
               state_in = ST_DIV;
            end else begin
               drop_ke_in = k_go;
               state_in   = ST_DROP_A;
            end
         end
         ST_RES_DONE: begin
            sm_x_in   = dq_ff[YW-1:0];
            sm_tgt_in = TGT_RES;
            state_in  = ST_SM_START;
         end
         ST_DROP_A: begin
            mul_a    = UV_W'(ma_ff);
            mul_b    = MW'(res_ff[YW-1:F]);
            prod_in  = mul_p;
            state_in = ST_DROP_B;
         end
         ST_DROP_B: begin
            p1_in    = prod_ff[DROP_W-1:0];
            mul_a    = UV_W'(ma_ff);
            mul_b    = MW'(res_ff[F-1:0]);
            prod_in  = mul_p;
            state_in = ST_DROP_C;
         end
         ST_DROP_C: begin
            drop_in  = p1_ff + DROP_W'(prod_ff >> F);
            state_in = drop_ke_ff ? ST_KE_EB : ST_BEMF_CALC;
         end
         ST_KE_EB: begin
            drop_ke_in = 1'b0;
            if (eb > $signed(EB_W'(1500000))) begin
               mul_a    = eb[UV_W-1:0];
               mul_b    = MW'(den);
               prod_in  = mul_p;
               state_in = ST_KE_RANGE;
            end else begin
               state_in = ST_DROP_A;
            end
         end
         ST_KE_RANGE: begin
            if ((kn > KN_W'(num_ff) * KN_W'(500)) && (kn < KN_W'(num_ff) * KN_W'(10000))) begin
               dq_in    = AW'(kn) << (AW - KN_W);
               rem_in   = '0;
               dsr_in   = DW'(num_ff);
               cnt_in   = CW'(KN_W + F);
               ret_in   = ST_KE_DONE;
               state_in = ST_DIV;
            end else begin
               state_in = ST_DROP_A;
            end
         end
         ST_KE_DONE: begin
            sm_x_in   = dq_ff[YW-1:0];
            sm_tgt_in = TGT_KE;
            state_in  = ST_SM_START;
         end
         ST_BEMF_CALC: begin
            bemf_in  = bemf_cur;
            dq_in    = AW'(bemf_cur) << (AW - UV_W);
            rem_in   = '0;
            dsr_in   = DW'(1000);
            cnt_in   = CW'(UV_W);
            ret_in   = ST_BEMF_Q;
            state_in = ST_DIV;
         end
         ST_BEMF_Q: begin
            // bemf rpm: bemf * 2^2f / ke
            bemf_mv_in = dq_ff[BEMF_W-1:0];
            dq_in      = AW'(bemf_ff) << (AW - UV_W);
            rem_in     = '0;
            dsr_in     = ke_ff;
            cnt_in     = CW'(AW);
            ret_in     = ST_SEL;
            state_in   = ST_DIV;
         end
         ST_SEL: begin
            sm_x_in   = raw[YW-1:0];
            sm_tgt_in = TGT_SPEED;
            state_in  = ST_SM_START;
         end
         ST_SM_START: begin
            sm_neg_in = sm_diff[YW];
            dq_in     = AW'(sm_mag) << (AW - YW);
            rem_in    = '0;
            dsr_in    = sm_div;
            cnt_in    = CW'(YW);
            ret_in    = ST_SM_APPLY;
            state_in  = ST_DIV;
         end
         ST_SM_APPLY: begin
            case (sm_tgt_ff)
               TGT_RES: begin
                  res_in     = sm_new;
                  drop_ke_in = 1'b0;
                  state_in   = ST_DROP_A;
               end
               TGT_KE: begin
                  ke_in      = sm_new;
                  drop_ke_in = 1'b0;
                  state_in   = ST_DROP_A;
               end
               default: begin
                  speed_in = (mv_ff < MV_W'(10)) ? '0 : sm_new;
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               o_speed_in   = speed_ff[F+SPEED_W-1:F];
               o_bemf_in    = bemf_mv_ff;
               o_res_in     = res_ff[YW-1:F];
               o_ke_in      = ke_ff[YW-1:F];
               o_used_in    = rip_sel_ff;
               o_stall_in   = (mv_ff > MV_W'(3500)) && (speed_ff < STALL_Q);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      dq_ff      <= dq_in;
      rem_ff     <= rem_in;
      dsr_ff     <= dsr_in;
      cnt_ff     <= cnt_in;
      mv_ff      <= mv_in;
      ma_ff      <= ma_in;
      num_ff     <= num_in;
      rip_q_ff   <= rip_q_in;
      sm_x_ff    <= sm_x_in;
      sm_neg_ff  <= sm_neg_in;
      prod_ff    <= prod_in;
      p1_ff      <= p1_in;
      drop_ff    <= drop_in;
      bemf_ff    <= bemf_in;
      bemf_mv_ff <= bemf_mv_in;
      o_speed_ff <= o_speed_in;
      o_bemf_ff  <= o_bemf_in;
      o_res_ff   <= o_res_in;
      o_ke_ff    <= o_ke_in;
      o_used_ff  <= o_used_in;
      o_stall_ff <= o_stall_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         sm_tgt_ff    <= TGT_RES;
         drop_ke_ff   <= 1'b0;
         pole_ff      <= POLE_RESET;
         res_ff       <= {RES_RESET, F'(0)};
         ke_ff        <= {KE_RESET, F'(0)};
         speed_ff     <= '0;
         rip_sel_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         sm_tgt_ff    <= sm_tgt_in;
         drop_ke_ff   <= drop_ke_in;
         pole_ff      <= pole_in;
         res_ff       <= res_in;
         ke_ff        <= ke_in;
         speed_ff     <= speed_in;
         // source flag only moves in the select step
         rip_sel_ff   <= (state_ff == ST_SEL) ? rip_sel_in : rip_sel_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_speed_rpm         = o_speed_ff;
   assign rsp_bemf_mv           = o_bemf_ff;
   assign rsp_resistance_mohm   = o_res_ff;
   assign rsp_ke_out_uv_per_rpm = o_ke_ff;
   assign rsp_used_ripple       = o_used_ff;
   assign rsp_stalled           = o_stall_ff;

   `MSEBR_ASSERT(a_accept_starts, (req_valid && !req_stall) |=> (state_ff != ST_IDLE), "request accepted but sequencer idle")
   `MSEBR_ASSERT(a_div_count, (state_ff == ST_DIV) |-> (cnt_ff != '0), "divider running with zero count")
   `MSEBR_ASSERT(a_ke_floor, ke_ff >= (YW'(1) << F), "learned ke below one")
   `MSEBR_ASSERT_NEVER(a_speed_cap, speed_ff > (YW'(65535) << F), "speed filter above cap")

endmodule
